[rtl/core/quasi_pr_current_controller_macros.svh]
// Assertion macros used by the controller top level.
`ifndef QUASI_PR_CURRENT_CONTROLLER_MACROS_SVH
`define QUASI_PR_CURRENT_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define QPRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define QPRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QPRC_ASSERT_IMP(lbl, ante, cons, msg)
`define QPRC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/qprc_pkg.sv]
// Types, constants and the step program shared by the controller modules.
`default_nettype none

package qprc_pkg;

    // Datapath widths.
    localparam int X_W      = 48;   // Q32.16 operand (delays, s, error)
    localparam int OPA_W    = 33;   // coefficient or gain, signed
    localparam int SPLIT    = 24;   // operand split point for the two passes
    localparam int OPB_W    = 25;   // one half of the operand plus a sign bit
    localparam int MUL_W    = OPA_W + OPB_W;
    localparam int PROD_W   = 81;   // full coefficient times operand product
    localparam int ACC_W    = 58;   // accumulator, holds the final sum
    localparam int E_W      = 17;   // reference minus measured
    localparam int IN_W     = 16;
    localparam int GAIN_W   = 24;
    localparam int COEF_W   = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int STEP_W   = 5;
    localparam int COEF_FRAC = 30;
    localparam int GAIN_FRAC = 16;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_PROP_GAIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_RES_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_B0   = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_B2   = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_A1   = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF_A2   = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRIVE_MAX = 3'd6;
    localparam logic [IDX_W-1:0] REG_DRIVE_MIN = 3'd7;

    localparam logic signed [IN_W-1:0] DRIVE_MAX_RST = 16'sh7FFF;
    localparam logic signed [IN_W-1:0] DRIVE_MIN_RST = 16'sh8000;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        ASEL_A1,
        ASEL_A2,
        ASEL_B0,
        ASEL_B2,
        ASEL_RG,
        ASEL_PG
    } asel_t;

    typedef enum logic [1:0] {
        XSEL_D1,
        XSEL_D2,
        XSEL_S,
        XSEL_E
    } xsel_t;

    typedef enum logic [1:0] {
        PROD_HOLD,
        PROD_LOAD,
        PROD_ADD
    } prod_op_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_E16,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_30
    } shift_t;

    typedef struct packed {
        logic     mul_en;
        logic     mul_hi;
        prod_op_t prod_op;
        shift_t   shift;
    } mac_ctrl_t;

    typedef struct packed {
        mac_ctrl_t mac;
        asel_t     a_sel;
        xsel_t     x_sel;
        acc_op_t   acc_op;
        logic      d_latch;
        logic      s_latch;
        logic      last;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   finish;
    } ctrl_t;

    typedef struct packed {
        logic        [GAIN_W-1:0] prop_gain;
        logic        [GAIN_W-1:0] res_gain;
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_b2;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
        logic signed [IN_W-1:0]   drive_max;
        logic signed [IN_W-1:0]   drive_min;
    } cfg_t;

    // Saturate an accumulator value to the signed Q32.16 range.
    function automatic logic signed [X_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [X_W-1:0] r;
        if (v[ACC_W-1:X_W-1] == {(ACC_W-X_W+1){v[ACC_W-1]}}) begin
            r = v[X_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(X_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(X_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Step program. Each product is issued as a low pass and a high pass; the
    // product register loads the low pass from the multiplier register, then adds
    // the high pass shifted up, and the accumulator takes the completed product.
    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '0;
        case (step)
            5'd0: begin
                uc.mac.mul_en = 1'b1; uc.a_sel = ASEL_A1; uc.x_sel = XSEL_D1;
                uc.acc_op = ACC_E16;
            end
            5'd1: begin
                uc.mac.mul_en = 1'b1; uc.mac.mul_hi = 1'b1;
                uc.a_sel = ASEL_A1; uc.x_sel = XSEL_D1;
                uc.mac.prod_op = PROD_LOAD;
            end
            5'd2: begin
                uc.mac.mul_en = 1'b1; uc.a_sel = ASEL_A2; uc.x_sel = XSEL_D2;
                uc.mac.prod_op = PROD_ADD;
            end
            5'd3: begin
                uc.mac.mul_en = 1'b1; uc.mac.mul_hi = 1'b1;
                uc.a_sel = ASEL_A2; uc.x_sel = XSEL_D2;
                uc.mac.prod_op = PROD_LOAD;
                uc.acc_op = ACC_SUB; uc.mac.shift = SH_30;
            end
            5'd4: begin
                uc.mac.mul_en = 1'b1; uc.a_sel = ASEL_B2; uc.x_sel = XSEL_D2;
                uc.mac.prod_op = PROD_ADD;
            end
            5'd5: begin
                uc.mac.mul_en = 1'b1; uc.mac.mul_hi = 1'b1;
                uc.a_sel = ASEL_B2; uc.x_sel = XSEL_D2;
                uc.mac.prod_op = PROD_LOAD;
                uc.acc_op = ACC_SUB; uc.mac.shift = SH_30;
            end
            5'd6: begin
                uc.mac.prod_op = PROD_ADD;
                uc.d_latch = 1'b1;
            end
            5'd7: begin
                uc.mac.mul_en = 1'b1; uc.a_sel = ASEL_B0; uc.x_sel = XSEL_D1;
                uc.acc_op = ACC_LOAD; uc.mac.shift = SH_30;
            end
            5'd8: begin
                uc.mac.mul_en = 1'b1; uc.mac.mul_hi = 1'b1;
                uc.a_sel = ASEL_B0; uc.x_sel = XSEL_D1;
                uc.mac.prod_op = PROD_LOAD;
            end
            5'd9: begin
                uc.mac.prod_op = PROD_ADD;
            end
            5'd10: begin
                uc.acc_op = ACC_ADD; uc.mac.shift = SH_30;
            end
            5'd11: begin
                uc.s_latch = 1'b1;
                uc.mac.mul_en = 1'b1; uc.a_sel = ASEL_PG; uc.x_sel = XSEL_E;
            end
            5'd12: begin
                uc.mac.mul_en = 1'b1; uc.mac.mul_hi = 1'b1;
                uc.a_sel = ASEL_PG; uc.x_sel = XSEL_E;
                uc.mac.prod_op = PROD_LOAD;
            end
            5'd13: begin
                uc.mac.mul_en = 1'b1; uc.a_sel = ASEL_RG; uc.x_sel = XSEL_S;
                uc.mac.prod_op = PROD_ADD;
            end
            5'd14: begin
                uc.mac.mul_en = 1'b1; uc.mac.mul_hi = 1'b1;
                uc.a_sel = ASEL_RG; uc.x_sel = XSEL_S;
                uc.mac.prod_op = PROD_LOAD;
                uc.acc_op = ACC_LOAD; uc.mac.shift = SH_0;
            end
            5'd15: begin
                uc.mac.prod_op = PROD_ADD;
            end
            5'd16: begin
                uc.acc_op = ACC_ADD; uc.mac.shift = SH_16;
            end
            5'd17: begin
                uc.last = 1'b1;
            end
            default: begin
                uc = '0;
            end
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

[rtl/core/qprc_cfg.sv]
// Configuration register file of the controller.
`default_nettype none

module qprc_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [qprc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [qprc_pkg::CFG_W-1:0]    cfg_wr_data,
    output qprc_pkg::cfg_t                     cfg
);

    qprc_pkg::cfg_t cfg_reg;
    qprc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                qprc_pkg::REG_PROP_GAIN: cfg_next.prop_gain = cfg_wr_data[23:0];
                qprc_pkg::REG_RES_GAIN:  cfg_next.res_gain  = cfg_wr_data[23:0];
                qprc_pkg::REG_COEF_B0:   cfg_next.coef_b0   = cfg_wr_data;
                qprc_pkg::REG_COEF_B2:   cfg_next.coef_b2   = cfg_wr_data;
                qprc_pkg::REG_COEF_A1:   cfg_next.coef_a1   = cfg_wr_data;
                qprc_pkg::REG_COEF_A2:   cfg_next.coef_a2   = cfg_wr_data;
                qprc_pkg::REG_DRIVE_MAX: cfg_next.drive_max = cfg_wr_data[15:0];
                qprc_pkg::REG_DRIVE_MIN: cfg_next.drive_min = cfg_wr_data[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{prop_gain: '0, res_gain: '0, coef_b0: '0, coef_b2: '0,
                         coef_a1: '0, coef_a2: '0,
                         drive_max: qprc_pkg::DRIVE_MAX_RST,
                         drive_min: qprc_pkg::DRIVE_MIN_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/core/qprc_mac.sv]
// Shared multiplier with product register and rounding shift.
`default_nettype none

module qprc_mac (
    input  wire logic                                 aclk,
    input  wire qprc_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [qprc_pkg::OPA_W-1:0]    op_a,
    input  wire logic signed [qprc_pkg::X_W-1:0]      op_x,
    output logic signed [qprc_pkg::ACC_W-1:0]         prod_shifted
);

    logic signed [qprc_pkg::OPB_W-1:0]  op_b;
    logic signed [qprc_pkg::MUL_W-1:0]  mul_prod;
    logic signed [qprc_pkg::MUL_W-1:0]  mul_reg;
    logic signed [qprc_pkg::MUL_W-1:0]  mul_next;
    logic signed [qprc_pkg::PROD_W-1:0] mul_ext;
    logic signed [qprc_pkg::PROD_W-1:0] prod_reg;
    logic signed [qprc_pkg::PROD_W-1:0] prod_next;
    logic signed [qprc_pkg::PROD_W-1:0] prod_sh;

    // The low pass treats the lower half as unsigned; the high pass carries the sign.
    always_comb begin
        if (ctrl.mul_hi) begin
            op_b = {op_x[qprc_pkg::X_W-1], op_x[qprc_pkg::X_W-1:qprc_pkg::SPLIT]};
        end else begin
            op_b = {1'b0, op_x[qprc_pkg::SPLIT-1:0]};
        end
    end

    assign mul_prod = op_a * op_b;
    assign mul_next = ctrl.mul_en ? mul_prod : mul_reg;
    assign mul_ext  = qprc_pkg::PROD_W'(mul_reg);

    always_comb begin
        case (ctrl.prod_op)
            qprc_pkg::PROD_LOAD: prod_next = mul_ext;
            qprc_pkg::PROD_ADD:  prod_next = prod_reg + (mul_ext <<< qprc_pkg::SPLIT);
            default:             prod_next = prod_reg;
        endcase
    end

    // Arithmetic right shift rounds toward minus infinity.
    always_comb begin
        case (ctrl.shift)
            qprc_pkg::SH_30: prod_sh = prod_reg >>> qprc_pkg::COEF_FRAC;
            qprc_pkg::SH_16: prod_sh = prod_reg >>> qprc_pkg::GAIN_FRAC;
            default:         prod_sh = prod_reg;
        endcase
    end

    assign prod_shifted = prod_sh[qprc_pkg::ACC_W-1:0];

    always_ff @(posedge aclk) begin
        mul_reg  <= mul_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

[rtl/core/qprc_seq.sv]
// Sequencer that steps the shared unit through one sample.
`default_nettype none

module qprc_seq (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        out_free,
    output logic             s_ready,
    output qprc_pkg::ctrl_t  ctrl
);

    qprc_pkg::state_t                 state_reg;
    qprc_pkg::state_t                 state_next;
    logic [qprc_pkg::STEP_W-1:0]      step_reg;
    logic [qprc_pkg::STEP_W-1:0]      step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qprc_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        s_ready     = 1'b0;
        ctrl        = '0;
        case (state_reg)
            qprc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = qprc_pkg::ST_RUN;
                    step_next  = '0;
                end
            end
            qprc_pkg::ST_RUN: begin
                ctrl.uc = qprc_pkg::ucode(step_reg);
                if (!ctrl.uc.last) begin
                    step_next = step_reg + 1'b1;
                end else if (out_free) begin
                    ctrl.finish = 1'b1;
                    state_next  = qprc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qprc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/quasi_pr_current_controller.sv]
// Top level of the quasi proportional-resonant current controller.
`default_nettype none
`include "quasi_pr_current_controller_macros.svh"

// Quasi proportional-resonant controller, one sample per input beat. The
// error is reference minus measured; the drive is prop_gain times the error
// plus res_gain times the output of a biquad with b1 fixed at zero, clamped
// to [drive_min, drive_max], with m_clamped set when a limit was applied.
// Gains are unsigned Q8.16, biquad coefficients signed Q2.30, and the two
// delay registers hold signed Q32.16 values that saturate instead of
// wrapping. Every product but the proportional one, which is exact in Q.16,
// is rounded toward minus infinity before it is summed. All six products go
// through a single 33 x 25 bit multiplier, two passes per product, under an
// 18-step sequencer, which works on one sample at a time: s_ready is high
// only while the sequencer is idle. The result sits in an output register,
// so the next input beat is accepted while an earlier result still waits
// for m_ready; the sequencer only holds at its final step if that register
// is still full and m_ready is low. Configuration registers
// are written through cfg_wr_en, cfg_index and cfg_wr_data with no wait
// state; they must only be written while no sample is in flight. Software
// computes the coefficients, including the pre-warped tangent term.
module quasi_pr_current_controller (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  cfg_wr_en,
    input  wire logic [qprc_pkg::IDX_W-1:0]            cfg_index,
    input  wire logic [qprc_pkg::CFG_W-1:0]            cfg_wr_data,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [qprc_pkg::IN_W-1:0]      s_reference,
    input  wire logic signed [qprc_pkg::IN_W-1:0]      s_measured,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [qprc_pkg::IN_W-1:0]           m_drive,
    output logic                                       m_clamped
);

    qprc_pkg::cfg_t  cfg;
    qprc_pkg::ctrl_t ctrl;

    logic                                 out_free;
    logic signed [qprc_pkg::OPA_W-1:0]    op_a;
    logic signed [qprc_pkg::X_W-1:0]      op_x;
    logic signed [qprc_pkg::ACC_W-1:0]    prod_shifted;

    logic signed [qprc_pkg::E_W-1:0]      e_reg;
    logic signed [qprc_pkg::E_W-1:0]      e_next;
    logic signed [qprc_pkg::ACC_W-1:0]    acc_reg;
    logic signed [qprc_pkg::ACC_W-1:0]    acc_next;
    logic signed [qprc_pkg::X_W-1:0]      delay_one_reg;
    logic signed [qprc_pkg::X_W-1:0]      delay_two_reg;
    logic signed [qprc_pkg::X_W-1:0]      s_reg;

    logic signed [qprc_pkg::ACC_W-1:0]    limit_hi;
    logic signed [qprc_pkg::ACC_W-1:0]    limit_lo;
    logic signed [qprc_pkg::ACC_W-1:0]    sum_floor;
    logic                                 m_valid_reg;
    logic                                 m_valid_next;
    logic signed [qprc_pkg::IN_W-1:0]     m_drive_reg;
    logic signed [qprc_pkg::IN_W-1:0]     m_drive_next;
    logic                                 m_clamped_reg;
    logic                                 m_clamped_next;

    qprc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    assign out_free = !m_valid_reg || m_ready;

    qprc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctrl     (ctrl)
    );

    // Operand selection for the shared multiplier. Gains are unsigned, so
    // they are zero extended into the signed operand.
    always_comb begin
        case (ctrl.uc.a_sel)
            qprc_pkg::ASEL_A1: op_a = qprc_pkg::OPA_W'(cfg.coef_a1);
            qprc_pkg::ASEL_A2: op_a = qprc_pkg::OPA_W'(cfg.coef_a2);
            qprc_pkg::ASEL_B0: op_a = qprc_pkg::OPA_W'(cfg.coef_b0);
            qprc_pkg::ASEL_B2: op_a = qprc_pkg::OPA_W'(cfg.coef_b2);
            qprc_pkg::ASEL_RG: op_a = {{(qprc_pkg::OPA_W-qprc_pkg::GAIN_W){1'b0}}, cfg.res_gain};
            qprc_pkg::ASEL_PG: op_a = {{(qprc_pkg::OPA_W-qprc_pkg::GAIN_W){1'b0}}, cfg.prop_gain};
            default:           op_a = '0;
        endcase
    end

    always_comb begin
        case (ctrl.uc.x_sel)
            qprc_pkg::XSEL_D1: op_x = delay_one_reg;
            qprc_pkg::XSEL_D2: op_x = delay_two_reg;
            qprc_pkg::XSEL_S:  op_x = s_reg;
            qprc_pkg::XSEL_E:  op_x = qprc_pkg::X_W'(e_reg);
            default:           op_x = '0;
        endcase
    end

    qprc_mac u_mac (
        .aclk         (aclk),
        .ctrl         (ctrl.uc.mac),
        .op_a         (op_a),
        .op_x         (op_x),
        .prod_shifted (prod_shifted)
    );

    // The error is captured exactly, one bit wider than the inputs.
    assign e_next = (s_valid && s_ready)
                  ? (qprc_pkg::E_W'(s_reference) - qprc_pkg::E_W'(s_measured))
                  : e_reg;

    // Accumulator: builds w, then s, then the final sum in Q.16.
    always_comb begin
        case (ctrl.uc.acc_op)
            qprc_pkg::ACC_E16:  acc_next = qprc_pkg::ACC_W'(e_reg) <<< qprc_pkg::GAIN_FRAC;
            qprc_pkg::ACC_LOAD: acc_next = prod_shifted;
            qprc_pkg::ACC_ADD:  acc_next = acc_reg + prod_shifted;
            qprc_pkg::ACC_SUB:  acc_next = acc_reg - prod_shifted;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        e_reg   <= e_next;
        acc_reg <= acc_next;
        if (ctrl.uc.s_latch) begin
            s_reg <= qprc_pkg::sat48(acc_reg);
        end
    end

    // Biquad state: the new w enters delay one once the feedback part is done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end else if (ctrl.uc.d_latch) begin
            delay_two_reg <= delay_one_reg;
            delay_one_reg <= qprc_pkg::sat48(acc_reg);
        end
    end

    // Clamp. The upper limit is tested first, so crossed limits resolve to
    // drive_max whenever the sum exceeds it.
    assign limit_hi  = qprc_pkg::ACC_W'(cfg.drive_max) <<< qprc_pkg::GAIN_FRAC;
    assign limit_lo  = qprc_pkg::ACC_W'(cfg.drive_min) <<< qprc_pkg::GAIN_FRAC;
    assign sum_floor = acc_reg >>> qprc_pkg::GAIN_FRAC;

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_drive_next   = m_drive_reg;
        m_clamped_next = m_clamped_reg;
        if (ctrl.finish) begin
            m_valid_next = 1'b1;
            if (acc_reg > limit_hi) begin
                m_drive_next   = cfg.drive_max;
                m_clamped_next = 1'b1;
            end else if (acc_reg < limit_lo) begin
                m_drive_next   = cfg.drive_min;
                m_clamped_next = 1'b1;
            end else begin
                m_drive_next   = sum_floor[qprc_pkg::IN_W-1:0];
                m_clamped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_drive_reg   <= m_drive_next;
        m_clamped_reg <= m_clamped_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_drive   = m_drive_reg;
    assign m_clamped = m_clamped_reg;

    // A finished sample always lands in the output register.
    `QPRC_ASSERT_NXT(a_finish_loads_out, ctrl.finish, m_valid_reg, "finished sample not presented")

    // A clamped result carries one of the limits in force when it was formed.
    `QPRC_ASSERT_NXT(a_clamp_is_limit, ctrl.finish, !m_clamped_reg || m_drive_reg == $past(cfg.drive_max) || m_drive_reg == $past(cfg.drive_min), "clamped drive is not a limit")

    // The biquad state moves only at its latch step.
    `QPRC_ASSERT_NXT(a_delay_hold, !ctrl.uc.d_latch, $stable(delay_one_reg) && $stable(delay_two_reg), "delay state changed outside its step")

endmodule

`default_nettype wire

[sim/quasi_pr_current_controller_tb.sv]
// Self-checking testbench for the quasi proportional-resonant current controller.
module quasi_pr_current_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // All predictor arithmetic runs in one wide signed type. The widest value
    // is a Q2.30 coefficient times a saturated Q32.16 delay, about 2^78, so
    // 128 bits hold every intermediate exactly and >>> floors correctly.
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [qprc_pkg::IN_W-1:0] drive;
        logic                             clamped;
    } drive_beat_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    // One row of the directed plan: either a register write or one sample.
    // A sample row may carry its expected drive typed in; otherwise the
    // predictor supplies it.
    typedef struct packed {
        row_kind_t                        kind;
        logic [qprc_pkg::IDX_W-1:0]       idx;
        logic [qprc_pkg::CFG_W-1:0]       data;
        logic signed [qprc_pkg::IN_W-1:0] reference_v;
        logic signed [qprc_pkg::IN_W-1:0] measured_v;
        logic                             typed;
        logic signed [qprc_pkg::IN_W-1:0] drive;
        logic                             clamped;
    } plan_row_t;

    localparam wide_t Q48_HI = 128'sh7FFF_FFFF_FFFF;
    localparam wide_t Q48_LO = -128'sh8000_0000_0000;

    // The slowest correct run is roughly 850 samples, each with its time in the
    // block plus sender gap and receiver stall; the limit is several times that.
    localparam int CYCLE_LIMIT     = 250000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int MAX_REPORTS     = 10;
    localparam int PLAN_LEN        = 37;

    // Directed plan. The first rows run with the reset settings and then
    // with the proportional path alone, so the expected drive can be read
    // off directly. The last group sets the biquad to diverge (a1 = a2 = -2)
    // and drives full-scale error until both delay registers and the biquad
    // output hit the Q32.16 rails; those rows are predicted.
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // Reset settings: all gains zero, so the drive is zero whatever comes in.
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd0, 1'b0},
        // Unity proportional gain: in-range error, then both limits.
        '{ROW_WRITE, qprc_pkg::REG_PROP_GAIN, 32'h0001_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd100, 16'sd30, 1'b1, 16'sd70, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF,
          1'b1},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000,
          1'b1},
        // Largest gain; the upper data byte must be ignored. Negative sums floor.
        '{ROW_WRITE, qprc_pkg::REG_PROP_GAIN, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd1, 16'sd0, 1'b1, 16'sd255, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd0, 16'sd1, 1'b1, -16'sd256, 1'b0},
        // Narrow limits of +/-100, upper data half ignored.
        '{ROW_WRITE, qprc_pkg::REG_DRIVE_MAX, 32'hFFFF_0064, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_DRIVE_MIN, 32'hFFFF_FF9C, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd1, 16'sd0, 1'b1, 16'sd100, 1'b1},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd0, 16'sd1, 1'b1, -16'sd100, 1'b1},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 1'b0},
        // Crossed limits: the upper test wins, so zero maps to drive_max.
        '{ROW_WRITE, qprc_pkg::REG_DRIVE_MAX, 32'h0000_FFCE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_DRIVE_MIN, 32'h0000_0032, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd0, 16'sd0, 1'b1, -16'sd50, 1'b1},
        // Back to full-range limits, resonant path only, diverging biquad.
        '{ROW_WRITE, qprc_pkg::REG_DRIVE_MAX, 32'h0000_7FFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_DRIVE_MIN, 32'h0000_8000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_RES_GAIN, 32'h0001_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_COEF_B0, 32'h8000_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_COEF_B2, 32'h4000_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_COEF_A1, 32'h8000_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, qprc_pkg::REG_COEF_A2, 32'h8000_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, qprc_pkg::REG_PROP_GAIN, 32'h0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 1'b0}
    };

    // Block ports. Every input has a known value from time zero.
    logic                             aclk;
    logic                             aresetn     = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [qprc_pkg::IDX_W-1:0]       cfg_index   = qprc_pkg::REG_PROP_GAIN;
    logic [qprc_pkg::CFG_W-1:0]       cfg_wr_data = '0;
    logic                             s_valid     = 1'b0;
    logic                             s_ready;
    logic signed [qprc_pkg::IN_W-1:0] s_reference = '0;
    logic signed [qprc_pkg::IN_W-1:0] s_measured  = '0;
    logic                             m_valid;
    logic                             m_ready     = 1'b0;
    logic signed [qprc_pkg::IN_W-1:0] m_drive;
    logic                             m_clamped;

    // Predictor copy of the registers and of the two biquad delays, held at
    // full precision. The limits come up at the full 16-bit range.
    wide_t pg_w   = '0;
    wide_t rg_w   = '0;
    wide_t b0_w   = '0;
    wide_t b2_w   = '0;
    wide_t a1_w   = '0;
    wide_t a2_w   = '0;
    wide_t dmax_w = 32767;
    wide_t dmin_w = -32768;
    wide_t d1_w   = '0;
    wide_t d2_w   = '0;

    // Expected drive beats, oldest first.
    drive_beat_t pending_drive_q [$];

    // Throttling of both channels, in percent of cycles spent idle.
    int src_idle_pct  = 19;
    int sink_idle_pct = 67;

    int cycle_count         = 0;
    int drive_mismatches    = 0;
    int drive_beats_checked = 0;
    int clamped_beats       = 0;
    int reg_writes          = 0;
    int q48_clips           = 0;

    quasi_pr_current_controller u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_reference (s_reference),
        .s_measured  (s_measured),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive     (m_drive),
        .m_clamped   (m_clamped)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Product of two fixed-point values, floored by 2^k.
    function automatic wide_t mul_floor(input wide_t a, input wide_t x, input int k);
        return (a * x) >>> k;
    endfunction

    // Saturate to the signed Q32.16 range and count how often it bites.
    function automatic wide_t clip_q48(input wide_t v);
        if (v > Q48_HI) begin
            q48_clips++;
            return Q48_HI;
        end
        if (v < Q48_LO) begin
            q48_clips++;
            return Q48_LO;
        end
        return v;
    endfunction

    // Drive produced by one sample, advancing the biquad delays. The biquad
    // is direct form II with b1 = 0: w = e - a1*d1 - a2*d2, s = b0*w + b2*d2.
    // Every coefficient product is floored to Q.16 before it is summed.
    function automatic drive_beat_t predict_drive(input logic signed [qprc_pkg::IN_W-1:0] r,
                                                  input logic signed [qprc_pkg::IN_W-1:0] m);
        wide_t       e;
        wide_t       w;
        wide_t       s;
        wide_t       sum;
        drive_beat_t beat;
        e = r;
        e = e - m;
        w = (e <<< qprc_pkg::GAIN_FRAC) - mul_floor(a1_w, d1_w, qprc_pkg::COEF_FRAC)
            - mul_floor(a2_w, d2_w, qprc_pkg::COEF_FRAC);
        w = clip_q48(w);
        s = clip_q48(mul_floor(b0_w, w, qprc_pkg::COEF_FRAC)
                     + mul_floor(b2_w, d2_w, qprc_pkg::COEF_FRAC));
        d2_w = d1_w;
        d1_w = w;
        // The proportional term is exact in Q.16; the resonant term is floored.
        sum = pg_w * e + mul_floor(rg_w, s, qprc_pkg::GAIN_FRAC);
        // The upper limit is tested first, which also settles crossed limits.
        if (sum > (dmax_w <<< qprc_pkg::GAIN_FRAC)) begin
            beat.drive   = dmax_w[qprc_pkg::IN_W-1:0];
            beat.clamped = 1'b1;
        end else if (sum < (dmin_w <<< qprc_pkg::GAIN_FRAC)) begin
            beat.drive   = dmin_w[qprc_pkg::IN_W-1:0];
            beat.clamped = 1'b1;
        end else begin
            beat.drive   = sum[qprc_pkg::GAIN_FRAC+qprc_pkg::IN_W-1:qprc_pkg::GAIN_FRAC];
            beat.clamped = 1'b0;
        end
        return beat;
    endfunction

    // One register write, mirrored into the predictor. Bits above the
    // register width are dropped; the gains zero-extend and the limits sign-extend.
    task automatic write_reg(input logic [qprc_pkg::IDX_W-1:0] idx,
                             input logic [qprc_pkg::CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            qprc_pkg::REG_PROP_GAIN: pg_w   = data[qprc_pkg::GAIN_W-1:0];
            qprc_pkg::REG_RES_GAIN:  rg_w   = data[qprc_pkg::GAIN_W-1:0];
            qprc_pkg::REG_COEF_B0:   b0_w   = $signed(data);
            qprc_pkg::REG_COEF_B2:   b2_w   = $signed(data);
            qprc_pkg::REG_COEF_A1:   a1_w   = $signed(data);
            qprc_pkg::REG_COEF_A2:   a2_w   = $signed(data);
            qprc_pkg::REG_DRIVE_MAX: dmax_w = $signed(data[qprc_pkg::IN_W-1:0]);
            qprc_pkg::REG_DRIVE_MIN: dmin_w = $signed(data[qprc_pkg::IN_W-1:0]);
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Present one sample and hold it until the block takes the beat. The
    // sender may sit idle for random cycles first.
    task automatic accept_sample(input logic signed [qprc_pkg::IN_W-1:0] r,
                                 input logic signed [qprc_pkg::IN_W-1:0] m);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_reference <= r;
        s_measured  <= m;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every expected drive beat has come back,
    // which leaves the block idle and safe for register writes.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [qprc_pkg::IN_W-1:0] extreme_input();
        case ($urandom_range(0, 3))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic logic [qprc_pkg::CFG_W-1:0] extreme_gain();
        case ($urandom_range(0, 3))
            0:       return 32'h0;
            1:       return 32'h1;
            2:       return 32'h00FF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [qprc_pkg::CFG_W-1:0] extreme_coef();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return 32'h4000_0000;
            4:       return 32'hC000_0000;
            default: return 32'h1;
        endcase
    endfunction

    function automatic logic [qprc_pkg::CFG_W-1:0] extreme_limit();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF;
            1:       return 32'h8000;
            2:       return 32'h0;
            default: return 32'hFFFF;
        endcase
    endfunction

    // Result side: the receiver throttles m_ready at random and every
    // accepted beat is compared against the oldest expectation.
    always @(posedge aclk) begin : drive_checker
        drive_beat_t want;
        if (m_valid && m_ready) begin
            if (pending_drive_q.size() == 0) begin
                drive_mismatches++;
                if (drive_mismatches <= MAX_REPORTS)
                    $display("unexpected drive beat: drive %0d clamped %0b",
                             m_drive, m_clamped);
            end else begin
                want = pending_drive_q.pop_front();
                drive_beats_checked++;
                if (m_clamped)
                    clamped_beats++;
                if (m_drive !== want.drive || m_clamped !== want.clamped) begin
                    drive_mismatches++;
                    if (drive_mismatches <= MAX_REPORTS)
                        $display("drive beat %0d: expected drive %0d clamped %0b, got %0d %0b",
                                 drive_beats_checked, want.drive, want.clamped,
                                 m_drive, m_clamped);
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // A run that stalls anywhere ends here.
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int                               i;
        int                               k;
        int                               mode;
        int                               style;
        plan_row_t                        row;
        drive_beat_t                      pred;
        logic signed [qprc_pkg::IN_W-1:0] r;
        logic signed [qprc_pkg::IN_W-1:0] m;
        logic [qprc_pkg::CFG_W-1:0]       pg;
        logic [qprc_pkg::CFG_W-1:0]       rg;
        logic [qprc_pkg::CFG_W-1:0]       b0;
        logic [qprc_pkg::CFG_W-1:0]       b2;
        logic [qprc_pkg::CFG_W-1:0]       a1;
        logic [qprc_pkg::CFG_W-1:0]       a2;
        logic [qprc_pkg::CFG_W-1:0]       dmax;
        logic [qprc_pkg::CFG_W-1:0]       dmin;
        longint                           a1v;
        longint                           a2v;
        longint                           b0v;
        longint                           bound;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan. Writes only go in once the block has drained. Every
        // sample runs through the predictor so that its delays follow the
        // block, even where the expected drive is typed in.
        for (i = 0; i < PLAN_LEN; i++) begin
            row = PLAN[i];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_reg(row.idx, row.data);
            end else begin
                accept_sample(row.reference_v, row.measured_v);
                pred = predict_drive(row.reference_v, row.measured_v);
                if (row.typed)
                    pending_drive_q.push_back(drive_beat_t'({row.drive, row.clamped}));
                else
                    pending_drive_q.push_back(pred);
            end
        end

        // Random part: three throttling modes (slow receiver, slow sender,
        // no throttling), each with three register settings. The delays are
        // never cleared, so each setting starts from whatever state the last
        // one left behind, saturated rails included.
        for (mode = 0; mode < 3; mode++) begin
            src_idle_pct  <= (mode == 0) ? 19 : (mode == 1) ? 67 : 0;
            sink_idle_pct <= (mode == 0) ? 67 : (mode == 1) ? 19 : 0;
            for (style = 0; style < 3; style++) begin
                settle();
                case (style)
                    0: begin
                        // A stable resonator: poles inside the unit circle with
                        // a2 just under one, b2 = -b0, moderate gains and
                        // random limits. Junk goes into the unused upper bits.
                        a2v   = (longint'(1) <<< 30) - longint'($urandom_range(1 << 16, 1 << 26));
                        bound = (longint'(1) <<< 30) + a2v - (longint'(1) <<< 20);
                        a1v   = longint'($urandom_range(0, 32'(2 * bound))) - bound;
                        b0v   = longint'($urandom_range(0, 1 << 25)) - (longint'(1) <<< 24);
                        pg    = {8'($urandom), 24'($urandom_range(0, 32'h0008_0000))};
                        rg    = {8'($urandom), 24'($urandom_range(0, 32'h0020_0000))};
                        b0    = 32'(b0v);
                        b2    = 32'(-b0v);
                        a1    = 32'(a1v);
                        a2    = 32'(a2v);
                        dmax  = {16'($urandom), 16'($urandom_range(500, 32767))};
                        dmin  = {16'($urandom), 16'(-longint'($urandom_range(500, 32768)))};
                    end
                    1: begin
                        // Anything goes, crossed limits and unstable filters too.
                        pg   = $urandom;
                        rg   = $urandom;
                        b0   = $urandom;
                        b2   = $urandom;
                        a1   = $urandom;
                        a2   = $urandom;
                        dmax = $urandom;
                        dmin = $urandom;
                    end
                    default: begin
                        pg   = extreme_gain();
                        rg   = extreme_gain();
                        b0   = extreme_coef();
                        b2   = extreme_coef();
                        a1   = extreme_coef();
                        a2   = extreme_coef();
                        dmax = extreme_limit();
                        dmin = extreme_limit();
                    end
                endcase
                write_reg(qprc_pkg::REG_PROP_GAIN, pg);
                write_reg(qprc_pkg::REG_RES_GAIN, rg);
                write_reg(qprc_pkg::REG_COEF_B0, b0);
                write_reg(qprc_pkg::REG_COEF_B2, b2);
                write_reg(qprc_pkg::REG_COEF_A1, a1);
                write_reg(qprc_pkg::REG_COEF_A2, a2);
                write_reg(qprc_pkg::REG_DRIVE_MAX, dmax);
                write_reg(qprc_pkg::REG_DRIVE_MIN, dmin);

                for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                    // Mix of full-range noise, small errors around a working
                    // point, rail values, and near-zero errors.
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            r = 16'($urandom);
                            m = 16'($urandom);
                        end
                        4, 5, 6: begin
                            r = 16'($urandom_range(0, 4000) - 2000);
                            m = 16'(r + ($urandom_range(0, 400) - 200));
                        end
                        7: begin
                            r = extreme_input();
                            m = extreme_input();
                        end
                        default: begin
                            r = 16'($urandom);
                            m = 16'(r + $urandom_range(0, 2) - 1);
                        end
                    endcase
                    accept_sample(r, m);
                    pending_drive_q.push_back(predict_drive(r, m));
                end
            end
        end

        // Drain, then give the block time to show any extra beat.
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_drive_q.size() != 0) begin
            $display("%0d expected drive beats never arrived", pending_drive_q.size());
            drive_mismatches += pending_drive_q.size();
        end

        $display("Checked %0d drive beats, %0d of them clamped, across %0d register writes.",
                 drive_beats_checked, clamped_beats, reg_writes);
        $display("Q32.16 saturation hit %0d times; three throttling modes were exercised.",
                 q48_clips);
        if (drive_mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
